/* rtl/v2x_per_cqi_tracker_defines.svh */
// ---------------------------------------------------------------------------
// v2x_per_cqi_tracker_defines
// Assertion macros shared by the tracker RTL.
// ---------------------------------------------------------------------------
`ifndef V2X_PER_CQI_TRACKER_DEFINES_SVH
`define V2X_PER_CQI_TRACKER_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define V2X_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define V2X_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/v2x_cqi_pkg.sv */
// ---------------------------------------------------------------------------
// v2x_cqi_pkg
// Types and constants of the remote vehicle error rate tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package v2x_cqi_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    localparam logic [31:0] AGING_RST  = 32'd5000;
    localparam logic [31:0] RECENT_RST = 32'd1000;
    localparam logic [15:0] RANGE_RST  = 16'd1000;
    localparam logic [15:0] CAP_RST    = 16'd32768;

    // register indexes on the config port
    localparam logic [1:0] REG_AGING  = 2'd0;
    localparam logic [1:0] REG_RECENT = 2'd1;
    localparam logic [1:0] REG_RANGE  = 2'd2;
    localparam logic [1:0] REG_CAP    = 2'd3;

    // request kinds
    localparam logic REQ_MSG  = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 17;

    typedef struct packed {
        logic [31:0] aging;
        logic [31:0] recent;
        logic [15:0] range_lim;
        logic [15:0] cap;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic [31:0]        id;
        logic [15:0]        first_cnt;
        logic [15:0]        last_cnt;
        logic [15:0]        total;
        logic [31:0]        last_t;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
    } entry_t;

endpackage

`default_nettype wire

/* rtl/v2x_cqi_div.sv */
// ---------------------------------------------------------------------------
// v2x_cqi_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module v2x_cqi_div
    import v2x_cqi_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 qbit;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, num_reg[DIV_NUM_W-1]};
        qbit      = trial >= {1'b0, den_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_NUM_W);
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = qbit ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            // quotient bits shift in where the dividend shifts out
            num_next = {num_reg[DIV_NUM_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;

endmodule

`default_nettype wire

/* rtl/v2x_cqi_regs.sv */
// ---------------------------------------------------------------------------
// v2x_cqi_regs
// Configuration registers behind the APB port.
// ---------------------------------------------------------------------------
`default_nettype none

module v2x_cqi_regs
    import v2x_cqi_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t cfg_reg, cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                REG_AGING:  cfg_next.aging     = pwdata;
                REG_RECENT: cfg_next.recent    = pwdata;
                REG_RANGE:  cfg_next.range_lim = pwdata[15:0];
                REG_CAP:    cfg_next.cap       = pwdata[15:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_AGING:  prdata = cfg_reg.aging;
            REG_RECENT: prdata = cfg_reg.recent;
            REG_RANGE:  prdata = {16'd0, cfg_reg.range_lim};
            REG_CAP:    prdata = {16'd0, cfg_reg.cap};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.aging     <= AGING_RST;
            cfg_reg.recent    <= RECENT_RST;
            cfg_reg.range_lim <= RANGE_RST;
            cfg_reg.cap       <= CAP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/v2x_per_cqi_tracker.sv */
// Message item: one table walk over the D table entries, then the entry write.
// Evaluate item: one table walk, R = entries rated with a loss; each such
// rate and the final average are computed on the shared divider.
// One item at a time; the next is taken once the result sits in the output register.
// Reset: synchronous, active low; clears valid bits, state, rated count and output valid, no clear pass.
// ---------------------------------------------------------------------------
// v2x_per_cqi_tracker
// Remote vehicle table with packet error rate and channel quality indicator.
// ---------------------------------------------------------------------------
`default_nettype none
`include "v2x_per_cqi_tracker_defines.svh"

module v2x_per_cqi_tracker
    import v2x_cqi_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // vehicle_id, msg_count, time_now, pos_x, pos_y, pos_z
    input  wire logic [151:0] s_tdata,
    // req_type
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // quality_index, vehicles_in_range, rated_vehicles, 4'b0
    output logic      [31:0]  m_tdata,
    // table_full
    output logic      [0:0]   m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W = 16 + CNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_RSQ    = 11'b00000000010,
        S_RD     = 11'b00000000100,
        S_CHK    = 11'b00000001000,
        S_SQY    = 11'b00000010000,
        S_DECIDE = 11'b00000100000,
        S_DIV    = 11'b00001000000,
        S_AVG    = 11'b00010000000,
        S_AVGW   = 11'b00100000000,
        S_MSGWR  = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    v2x_cqi_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    v2x_cqi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // table storage
    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             req_reg, req_next;
    logic [31:0]      id_reg, id_next;
    logic [15:0]      cnt_reg, cnt_next;
    logic [31:0]      now_reg, now_next;
    logic [23:0]      px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [15:0]      hit_first_reg, hit_first_next;
    logic [15:0]      hit_total_reg, hit_total_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [31:0]      r2_reg, r2_next;
    logic [49:0]      sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic             recent_reg, recent_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] rated_reg, rated_next;
    logic [CNT_W-1:0] dens_reg, dens_next;
    logic [15:0]      qual_reg, qual_next;
    logic             full_reg, full_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] use_reg, use_next;
    logic [TABLE_DEPTH-1:0] single_reg, single_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [31:0]      m_tdata_reg, m_tdata_next;
    logic             m_tuser_reg, m_tuser_next;

    // shared multiplier
    logic [24:0] mult_a;
    logic [49:0] prod;

    logic        step;
    logic [31:0] age;
    logic signed [24:0] dx, dy;
    logic [24:0] adx, ady;
    logic [50:0] dist_sq;
    logic        in_rng;
    logic        use_ok;
    logic [16:0] expected;
    logic [16:0] diff;

    always_comb begin
        age      = now_reg - rdata_reg.last_t;
        dx       = 25'(rdata_reg.x) - 25'($signed(px_reg));
        dy       = 25'(rdata_reg.y) - 25'($signed(py_reg));
        adx      = dx[24] ? 25'(-dx) : 25'(dx);
        ady      = dy[24] ? 25'(-dy) : 25'(dy);
        dist_sq  = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        in_rng   = dist_sq <= {19'd0, r2_reg};
        expected = 17'd1 + {1'b0, 16'(rdata_reg.last_cnt - rdata_reg.first_cnt)};
        diff     = expected - {1'b0, rdata_reg.total};
        use_ok   = use_reg[idx_reg] && !single_reg[idx_reg] && recent_reg && in_rng;
    end

    always_comb begin
        case (state_reg)
            S_RSQ:   mult_a = {9'd0, cfg.range_lim};
            S_CHK:   mult_a = adx;
            S_SQY:   mult_a = ady;
            default: mult_a = '0;
        endcase
        prod = mult_a * mult_a;
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        req_next        = req_reg;
        id_next         = id_reg;
        cnt_next        = cnt_reg;
        now_next        = now_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        pz_next         = pz_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_first_next  = hit_first_reg;
        hit_total_next  = hit_total_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        r2_next         = r2_reg;
        sqx_next        = sqx_reg;
        sqy_next        = sqy_reg;
        recent_next     = recent_reg;
        sum_next        = sum_reg;
        rated_next      = rated_reg;
        dens_next       = dens_reg;
        qual_next       = qual_reg;
        full_next       = full_reg;
        valid_next      = valid_reg;
        use_next        = use_reg;
        single_next     = single_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        div_req         = '0;
        step            = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next        = s_tuser[0];
                    id_next         = s_tdata[31:0];
                    cnt_next        = s_tdata[47:32];
                    now_next        = s_tdata[79:48];
                    px_next         = s_tdata[103:80];
                    py_next         = s_tdata[127:104];
                    pz_next         = s_tdata[151:128];
                    idx_next        = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    sum_next        = '0;
                    rated_next      = '0;
                    dens_next       = '0;
                    qual_next       = '0;
                    full_next       = 1'b0;
                    state_next      = (s_tuser[0] == REQ_EVAL) ? S_RSQ : S_RD;
                end
            end
            S_RSQ: begin
                r2_next    = prod[31:0];
                state_next = S_RD;
            end
            S_RD: begin
                if (valid_reg[idx_reg]) begin
                    state_next = S_CHK;
                end else begin
                    if (req_reg == REQ_MSG && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    step = 1'b1;
                end
            end
            S_CHK: begin
                if (req_reg == REQ_MSG) begin
                    if (!hit_found_reg && rdata_reg.id == id_reg) begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = idx_reg;
                        hit_first_next = rdata_reg.first_cnt;
                        hit_total_next = rdata_reg.total;
                    end
                    step = 1'b1;
                end else if (age > cfg.aging) begin
                    valid_next[idx_reg] = 1'b0;
                    step = 1'b1;
                end else begin
                    recent_next = age <= cfg.recent;
                    sqx_next    = prod;
                    state_next  = S_SQY;
                end
            end
            S_SQY: begin
                sqy_next   = prod;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (recent_reg && in_rng) begin
                    dens_next = dens_reg + 1'b1;
                end
                use_next[idx_reg] = use_ok;
                if (use_ok && {1'b0, rdata_reg.total} < expected) begin
                    div_req.start = 1'b1;
                    div_req.num   = {diff[15:0], 16'd0};
                    div_req.den   = expected;
                    state_next    = S_DIV;
                end else begin
                    if (use_ok) begin
                        rated_next = rated_reg + 1'b1;
                    end
                    step = 1'b1;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    sum_next   = sum_reg + SUM_W'(div_rsp.quot[15:0]);
                    rated_next = rated_reg + 1'b1;
                    step       = 1'b1;
                end
            end
            S_AVG: begin
                if (rated_reg == '0) begin
                    qual_next  = '0;
                    state_next = S_OUT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_NUM_W'(sum_reg);
                    div_req.den   = DIV_DEN_W'(rated_reg);
                    state_next    = S_AVGW;
                end
            end
            S_AVGW: begin
                if (div_rsp.done) begin
                    qual_next  = (div_rsp.quot[15:0] > cfg.cap) ? cfg.cap
                                                                : div_rsp.quot[15:0];
                    state_next = S_OUT;
                end
            end
            S_MSGWR: begin
                mem_wdata.id     = id_reg;
                mem_wdata.last_cnt = cnt_reg;
                mem_wdata.last_t = now_reg;
                mem_wdata.x      = px_reg;
                mem_wdata.y      = py_reg;
                mem_wdata.z      = pz_reg;
                if (hit_found_reg) begin
                    mem_we              = 1'b1;
                    mem_waddr           = hit_idx_reg;
                    mem_wdata.first_cnt = hit_first_reg;
                    mem_wdata.total     = (hit_total_reg == 16'hFFFF) ? hit_total_reg
                                                                      : hit_total_reg + 1'b1;
                    single_next[hit_idx_reg] = 1'b0;
                    use_next[hit_idx_reg]    = 1'b1;
                end else if (free_found_reg) begin
                    mem_we              = 1'b1;
                    mem_waddr           = free_idx_reg;
                    mem_wdata.first_cnt = cnt_reg;
                    mem_wdata.total     = 16'd1;
                    valid_next[free_idx_reg]  = 1'b1;
                    single_next[free_idx_reg] = 1'b1;
                    use_next[free_idx_reg]    = 1'b0;
                end else begin
                    full_next = 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'd0, 6'(rated_reg), 6'(dens_reg), qual_reg};
                    m_tuser_next  = full_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (step) begin
            if (idx_reg == LAST_IDX) begin
                state_next = (req_reg == REQ_EVAL) ? S_AVG : S_MSGWR;
            end else begin
                idx_next   = idx_reg + 1'b1;
                state_next = S_RD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_RD) begin
            rdata_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            rated_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            rated_reg    <= rated_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        idx_reg        <= idx_next;
        req_reg        <= req_next;
        id_reg         <= id_next;
        cnt_reg        <= cnt_next;
        now_reg        <= now_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        pz_reg         <= pz_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_first_reg  <= hit_first_next;
        hit_total_reg  <= hit_total_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        r2_reg         <= r2_next;
        sqx_reg        <= sqx_next;
        sqy_reg        <= sqy_next;
        recent_reg     <= recent_next;
        sum_reg        <= sum_next;
        dens_reg       <= dens_next;
        qual_reg       <= qual_next;
        full_reg       <= full_next;
        use_reg        <= use_next;
        single_reg     <= single_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `V2X_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `V2X_ASSERT_IMP(a_full_zero, m_tvalid && m_tuser[0], m_tdata[27:0] == 28'd0, "full result not zero")
    `V2X_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
    `V2X_ASSERT_IMP(a_rated_bound, s_tready, rated_reg <= CNT_W'(TABLE_DEPTH), "rated count overflow")

endmodule

`default_nettype wire
